// ----- src/biou_pkg.sv -----
package biou_pkg;

  typedef struct packed {
    logic empty;
    logic sat;
  } biou_flags_t;

endpackage

// ----- src/biou_divider.sv -----
module biou_divider #(
  parameter int DEN_BITS = 33,
  parameter int Q_BITS   = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [DEN_BITS-1:0]  in_num,
  input  logic [DEN_BITS-1:0]  in_den,
  input  biou_pkg::biou_flags_t in_flags,
  output logic                 out_valid,
  output logic [Q_BITS-1:0]    out_q,
  output biou_pkg::biou_flags_t out_flags
);
  import biou_pkg::*;

  logic                valid_r [1:Q_BITS];
  biou_flags_t         flags_r [1:Q_BITS];
  logic [Q_BITS-1:0]   q_r     [1:Q_BITS];
  logic [DEN_BITS-1:0] rem_r   [1:Q_BITS-1];
  logic [DEN_BITS-1:0] den_r   [1:Q_BITS-1];

  // one quotient bit per stage, restoring division
  for (genvar k = 1; k <= Q_BITS; k++) begin : g_step
    logic [DEN_BITS-1:0] rem_in;
    logic [DEN_BITS-1:0] den_in;
    logic [Q_BITS-1:0]   q_in;
    logic                v_in;
    biou_flags_t         f_in;
    logic [DEN_BITS:0]   sh;
    logic                take;

    if (k == 1) begin : g_first
      assign rem_in = in_num;
      assign den_in = in_den;
      assign q_in   = '0;
      assign v_in   = in_valid;
      assign f_in   = in_flags;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign q_in   = q_r[k-1];
      assign v_in   = valid_r[k-1];
      assign f_in   = flags_r[k-1];
    end

    assign sh   = {rem_in, 1'b0};
    assign take = (sh >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else if (en) begin
        valid_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[k]     <= {q_in[Q_BITS-2:0], take};
        flags_r[k] <= f_in;
      end
    end

    if (k < Q_BITS) begin : g_carry
      logic [DEN_BITS:0] diff;

      assign diff = sh - {1'b0, den_in};

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= take ? diff[DEN_BITS-1:0] : sh[DEN_BITS-1:0];
          den_r[k] <= den_in;
        end
      end
    end
  end

  assign out_valid = valid_r[Q_BITS];
  assign out_q     = q_r[Q_BITS];
  assign out_flags = flags_r[Q_BITS];

endmodule

// ----- src/box_iou_unit.sv -----
// Throughput: one box pair per cycle while no output stall holds the pipeline; four
// arithmetic stages, one stage per quotient bit in the divider, and an output register.
// A stall at the output while it holds a valid result freezes the whole pipeline; in_stall follows it.
// Reset (rst_n low, synchronous) clears all valid bits; data registers are not reset.
module box_iou_unit #(
  parameter int COORD_BITS      = 16,
  parameter int RATIO_FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [COORD_BITS-1:0]    in_a_xmin,
  input  logic [COORD_BITS-1:0]    in_a_ymin,
  input  logic [COORD_BITS-1:0]    in_a_xmax,
  input  logic [COORD_BITS-1:0]    in_a_ymax,
  input  logic [COORD_BITS-1:0]    in_b_xmin,
  input  logic [COORD_BITS-1:0]    in_b_ymin,
  input  logic [COORD_BITS-1:0]    in_b_xmax,
  input  logic [COORD_BITS-1:0]    in_b_ymax,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [RATIO_FRAC_BITS:0] out_iou,
  output logic                     out_union_empty
);
  import biou_pkg::*;

  localparam int C      = COORD_BITS;
  localparam int F      = RATIO_FRAC_BITS;
  localparam int PROD_W = 2 * C;
  localparam int AREA_W = 2 * C + 2;
  localparam int UNI_W  = 2 * C + 3;
  localparam int DEN_W  = 2 * C + 1;
  localparam logic [F:0] RATIO_ONE = (F+1)'(1) << F;

  logic en;

  // stage 1: overlap extents and box sides
  logic                s1_valid_r;
  logic [C-1:0]        ow_r, oh_r;
  logic signed [C:0]   wa_r, ha_r, wb_r, hb_r;
  logic [C-1:0]        minx, maxx, miny, maxy;
  logic [C:0]          ow_full, oh_full;

  // stage 2: products
  logic                     s2_valid_r;
  logic [PROD_W-1:0]        inter_s2_r;
  logic signed [AREA_W-1:0] area_a_r, area_b_r;

  // stage 3: union
  logic                    s3_valid_r;
  logic [PROD_W-1:0]       inter_s3_r;
  logic signed [UNI_W-1:0] uni_r;

  // stage 4: classify and set up division
  logic              s4_valid_r;
  biou_flags_t       s4_flags_r;
  logic [DEN_W-1:0]  num_r, den_r;
  logic              empty_nxt, sat_nxt;

  // divider and output
  logic              div_valid;
  logic [F-1:0]      div_q;
  biou_flags_t       div_flags;
  logic              out_valid_r;
  logic [F:0]        iou_r, iou_nxt;
  logic              empty_r;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  assign minx    = (in_a_xmax < in_b_xmax) ? in_a_xmax : in_b_xmax;
  assign maxx    = (in_a_xmin > in_b_xmin) ? in_a_xmin : in_b_xmin;
  assign miny    = (in_a_ymax < in_b_ymax) ? in_a_ymax : in_b_ymax;
  assign maxy    = (in_a_ymin > in_b_ymin) ? in_a_ymin : in_b_ymin;
  assign ow_full = {1'b0, minx} - {1'b0, maxx};
  assign oh_full = {1'b0, miny} - {1'b0, maxy};

  assign empty_nxt = uni_r[UNI_W-1] || (uni_r == '0);
  assign sat_nxt   = !empty_nxt && (UNI_W'(inter_s3_r) >= $unsigned(uni_r));

  always_comb begin
    priority if (div_flags.empty) begin
      iou_nxt = '0;
    end else if (div_flags.sat) begin
      iou_nxt = RATIO_ONE;
    end else begin
      iou_nxt = {1'b0, div_q};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r  <= in_valid;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      s4_valid_r  <= s3_valid_r;
      out_valid_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ow_r <= ow_full[C] ? '0 : ow_full[C-1:0];
      oh_r <= oh_full[C] ? '0 : oh_full[C-1:0];
      wa_r <= $signed({1'b0, in_a_xmax} - {1'b0, in_a_xmin});
      ha_r <= $signed({1'b0, in_a_ymax} - {1'b0, in_a_ymin});
      wb_r <= $signed({1'b0, in_b_xmax} - {1'b0, in_b_xmin});
      hb_r <= $signed({1'b0, in_b_ymax} - {1'b0, in_b_ymin});

      inter_s2_r <= PROD_W'(ow_r) * PROD_W'(oh_r);
      area_a_r   <= AREA_W'(wa_r) * AREA_W'(ha_r);
      area_b_r   <= AREA_W'(wb_r) * AREA_W'(hb_r);

      inter_s3_r <= inter_s2_r;
      uni_r      <= UNI_W'(area_a_r) + UNI_W'(area_b_r)
                    - UNI_W'($signed({1'b0, inter_s2_r}));

      s4_flags_r.empty <= empty_nxt;
      s4_flags_r.sat   <= sat_nxt;
      num_r <= (empty_nxt || sat_nxt) ? '0 : DEN_W'(inter_s3_r);
      den_r <= (empty_nxt || sat_nxt) ? DEN_W'(1) : uni_r[DEN_W-1:0];

      iou_r   <= iou_nxt;
      empty_r <= div_flags.empty;
    end
  end

  biou_divider #(
    .DEN_BITS (DEN_W),
    .Q_BITS   (F)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s4_valid_r),
    .in_num    (num_r),
    .in_den    (den_r),
    .in_flags  (s4_flags_r),
    .out_valid (div_valid),
    .out_q     (div_q),
    .out_flags (div_flags)
  );

  assign out_valid       = out_valid_r;
  assign out_iou         = iou_r;
  assign out_union_empty = empty_r;

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> s1_valid_r)
    else $error("accepted item did not enter stage 1");

  a_div_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
    (div_valid && en) |=> out_valid_r)
    else $error("divider result lost before output");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    s4_valid_r |-> !(s4_flags_r.empty && s4_flags_r.sat))
    else $error("empty and saturate both set");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && empty_r) |-> (iou_r == '0))
    else $error("empty union with nonzero ratio");

  a_ratio_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (iou_r <= RATIO_ONE))
    else $error("ratio above one");

endmodule
